// ===== design/sfr_pkg.sv =====
// Shared types and constants for the sum8 frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam logic [7:0] HDR_BYTE = 8'h62;   // ASCII 'b'

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADHDR   = 2'd1;
    localparam logic [1:0] ST_TOOLONG  = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd255;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic [7:0] frame_length;
    } result_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] bytes_left;
    } parse_state_t;

endpackage

// ===== design/sfr_in_stage.sv =====
// Input register: holds one received word until the parser consumes it.
`timescale 1ns / 1ps

module sfr_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= rx_byte;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== design/sfr_parser.sv =====
// Frame parser: phase, running sum, length tracking and result formation.
`timescale 1ns / 1ps

module sfr_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [7:0]           cfg_data,
    input  logic                 advance,
    input  logic [7:0]           cur_byte,
    output logic                 has_result,
    output sfr_pkg::result_t     result,
    output sfr_pkg::parse_state_t pstate
);

    logic [7:0] max_payload_reg;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] length_seen_reg;
    logic [7:0] length_seen_next;
    logic [7:0] sum_add;
    logic [7:0] left_dec;

    assign sum_add  = running_sum_reg + cur_byte;
    assign left_dec = bytes_left_reg - 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        running_sum_next = running_sum_reg;
        bytes_left_next  = bytes_left_reg;
        length_seen_next = length_seen_reg;
        has_result       = 1'b0;
        result           = '0;
        case (phase_reg)
            sfr_pkg::PH_HUNT:
            begin
                if (cur_byte != sfr_pkg::HDR_BYTE)
                begin
                    has_result    = 1'b1;
                    result.kind   = sfr_pkg::KIND_STATUS;
                    result.status = sfr_pkg::ST_BADHDR;
                end
                else
                begin
                    running_sum_next = sfr_pkg::HDR_BYTE;
                    phase_next       = sfr_pkg::PH_LEN;
                end
            end
            sfr_pkg::PH_LEN:
            begin
                if (cur_byte > max_payload_reg)
                begin
                    phase_next          = sfr_pkg::PH_HUNT;
                    running_sum_next    = '0;
                    bytes_left_next     = '0;
                    has_result          = 1'b1;
                    result.kind         = sfr_pkg::KIND_STATUS;
                    result.status       = sfr_pkg::ST_TOOLONG;
                    result.frame_length = cur_byte;
                end
                else
                begin
                    running_sum_next = sum_add;
                    bytes_left_next  = cur_byte;
                    length_seen_next = cur_byte;
                    phase_next       = (cur_byte == 8'd0) ? sfr_pkg::PH_SUM
                                                          : sfr_pkg::PH_DATA;
                end
            end
            sfr_pkg::PH_DATA:
            begin
                running_sum_next = sum_add;
                bytes_left_next  = left_dec;
                if (left_dec == 8'd0)
                    phase_next = sfr_pkg::PH_SUM;
                has_result       = 1'b1;
                result.kind      = sfr_pkg::KIND_DATA;
                result.data_byte = cur_byte;
            end
            default:
            begin
                phase_next          = sfr_pkg::PH_HUNT;
                running_sum_next    = '0;
                bytes_left_next     = '0;
                has_result          = 1'b1;
                result.kind         = sfr_pkg::KIND_STATUS;
                result.status       = (cur_byte == running_sum_reg) ? sfr_pkg::ST_OK
                                                                    : sfr_pkg::ST_MISMATCH;
                result.frame_length = length_seen_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= sfr_pkg::MAX_PAYLOAD_RST;
            phase_reg       <= sfr_pkg::PH_HUNT;
            running_sum_reg <= '0;
            bytes_left_reg  <= '0;
            length_seen_reg <= '0;
        end
        else
        begin
            if (cfg_write)
                max_payload_reg <= cfg_data;
            if (advance)
            begin
                phase_reg       <= phase_next;
                running_sum_reg <= running_sum_next;
                bytes_left_reg  <= bytes_left_next;
                length_seen_reg <= length_seen_next;
            end
        end
    end

    assign pstate.phase      = phase_reg;
    assign pstate.bytes_left = bytes_left_reg;

endmodule

// ===== design/sfr_out_stage.sv =====
// Result register: holds one result word until the sink takes it.
`timescale 1ns / 1ps

module sfr_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sfr_pkg::result_t load_data,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output sfr_pkg::result_t held
);

    logic             valid_reg;
    logic             valid_next;
    sfr_pkg::result_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

// ===== design/sum8_frame_receiver.sv =====
// Top level of the sum8 frame receiver: input register, parser, result register.
`timescale 1ns / 1ps

// Parses a byte stream of frames: header 'b', length L, L payload bytes, and a
// checksum equal to the mod-256 sum of header, length and payload. Each payload
// byte comes out at once as a kind 0 word; the checksum byte gives a kind 1 word
// with status ok or mismatch and the frame length. A wrong header (status 1) or
// a length above max_payload (status 2, length reported) is flagged right away
// and the parser goes back to hunting for a header. Header and accepted length
// bytes produce no output word. Rate: one input word per cycle unless the input
// side stalls. A word is captured in the input register, where the parser's add,
// compare and phase update run, and its result is then loaded into the output
// register, which drives out_valid. The input side stalls only when a word with
// a result meets a full output register that the sink is not draining.
// cfg_ready is always high; write max_payload only while the block is idle.
module sum8_frame_receiver
(
    input  logic       clk,
    input  logic       rst_n,
    // byte input
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    // result output
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic [1:0] status,
    output logic [7:0] frame_length,
    // max_payload write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic                  held_valid;
    logic [7:0]            held_byte;
    logic                  has_result;
    logic                  out_free;
    logic                  advance;
    logic                  load;
    sfr_pkg::result_t      result;
    sfr_pkg::result_t      out_word;
    sfr_pkg::parse_state_t pstate;

    // A held word moves on when it yields nothing or the result slot is free.
    assign advance   = held_valid && (!has_result || out_free);
    assign load      = advance && has_result;
    assign cfg_ready = 1'b1;

    sfr_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sfr_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .advance    (advance),
        .cur_byte   (held_byte),
        .has_result (has_result),
        .result     (result),
        .pstate     (pstate)
    );

    sfr_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (out_word)
    );

    assign kind         = out_word.kind;
    assign data_byte    = out_word.data_byte;
    assign status       = out_word.status;
    assign frame_length = out_word.frame_length;

    // never overwrite a result the sink has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && out_valid && !out_ready))
        else $error("result register overwritten while stalled");

    // payload phase always has bytes outstanding
    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        (pstate.phase == sfr_pkg::PH_DATA) |-> (pstate.bytes_left != 8'd0))
        else $error("payload phase with zero bytes left");

    // payload words carry no status or length
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == sfr_pkg::KIND_DATA) |->
            (status == sfr_pkg::ST_OK && frame_length == 8'd0))
        else $error("payload word with status fields set");

    // a held byte that cannot move keeps the parser state
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid && !advance) |=> ($stable(pstate) && $stable(held_byte)))
        else $error("parser state moved during stall");

endmodule
